[design/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types, character codes and helpers for the printf format engine
// ----------------------------------------------------------------------------
package pfe_pkg;

  // request kinds carried on the input tuser
  localparam logic [1:0] REQ_FMT = 2'd0;
  localparam logic [1:0] REQ_STR = 2'd1;
  localparam logic [1:0] REQ_END = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_X       = 8'h78;

  localparam logic [127:0] DIGIT_CHARS = "0123456789abcdef";

  // q = (v * RECIP10) >> RECIP_SHIFT is exact v / 10 for any 32-bit v
  localparam logic [31:0] RECIP10     = 32'hcccc_cccd;
  localparam int          RECIP_SHIFT = 35;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = DIGIT_CHARS[8*(15 - int'(d)) +: 8];
  endfunction

  typedef struct packed {
    logic load;
    logic div_step;
    logic pre_emit;
    logic num_emit;
    logic term_emit;
  } pfe_cmd_t;

  typedef struct packed {
    logic num_en;
    logic end_en;
    logic pre_left;
    logic div_done;
    logic num_fits;
    logic num_last;
    logic out_free;
  } pfe_stat_t;

endpackage

[design/pfe_dp.sv]
// ----------------------------------------------------------------------------
// pfe_dp
// datapath: request decode, digit generator, digit store, count and out beat
// ----------------------------------------------------------------------------
module pfe_dp #(
  parameter int DIGIT_SLOTS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  pfe_pkg::pfe_cmd_t cmd,
  output pfe_pkg::pfe_stat_t stat,
  input  logic [15:0]       buffer_size,
  input  logic [1:0]        req_type,
  input  logic [7:0]        in_char,
  input  logic [31:0]       arg_value,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_char,
  output logic [15:0]       out_position,
  output logic              is_end,
  output logic [15:0]       total_length
);
  import pfe_pkg::*;

  localparam int IW = $clog2(DIGIT_SLOTS);
  localparam int NW = $clog2(DIGIT_SLOTS + 1);
  localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [LW-1:0] CMASK = {LW{1'b1}} >> (LW - COUNT_BITS);

  // control state
  logic [COUNT_BITS-1:0] count;
  logic                  after_percent;
  logic                  in_string_arg;
  logic [1:0]            pre_n;
  logic                  num_en;
  logic                  base16;
  logic                  neg;
  logic                  end_en;
  logic [NW-1:0]         nd;

  // payload
  logic [7:0]  pre0;
  logic [7:0]  pre1;
  logic [31:0] mag;
  logic [3:0]  scratch [DIGIT_SLOTS];

  // decode of the incoming request
  logic [7:0]  d_pre0;
  logic [7:0]  d_pre1;
  logic [1:0]  d_pre_n;
  logic        d_num_en;
  logic        d_base16;
  logic        d_neg;
  logic        d_end_en;
  logic [31:0] d_mag;
  logic        d_apf;
  logic        d_str;

  always_comb begin
    d_pre0   = in_char;
    d_pre1   = in_char;
    d_pre_n  = 2'd0;
    d_num_en = 1'b0;
    d_base16 = 1'b0;
    d_neg    = 1'b0;
    d_end_en = 1'b0;
    d_mag    = arg_value;
    d_apf    = after_percent;
    d_str    = in_string_arg;
    case (req_type)
      REQ_STR: begin
        if (in_string_arg) begin
          if (in_char == CH_NUL) begin
            d_str = 1'b0;
          end else begin
            d_pre_n = 2'd1;
          end
        end
      end
      REQ_END: begin
        d_pre0   = CH_PERCENT;
        d_pre_n  = after_percent ? 2'd1 : 2'd0;
        d_end_en = 1'b1;
        d_apf    = 1'b0;
        d_str    = 1'b0;
      end
      REQ_FMT: begin
        d_str = 1'b0;
        if (in_char != CH_NUL) begin
          if (!after_percent) begin
            if (in_char == CH_PERCENT) begin
              d_apf = 1'b1;
            end else begin
              d_pre_n = 2'd1;
            end
          end else begin
            d_apf = 1'b0;
            case (in_char)
              CH_C: begin
                d_pre0  = arg_value[7:0];
                d_pre_n = 2'd1;
              end
              CH_D, CH_I: begin
                d_num_en = 1'b1;
                d_neg    = arg_value[31];
                d_mag    = arg_value[31] ? (32'd0 - arg_value) : arg_value;
              end
              CH_U: begin
                d_num_en = 1'b1;
              end
              CH_X: begin
                d_pre0   = CH_ZERO;
                d_pre1   = CH_X;
                d_pre_n  = 2'd2;
                d_num_en = 1'b1;
                d_base16 = 1'b1;
              end
              CH_S: begin
                d_str = 1'b1;
              end
              CH_PERCENT: begin
                d_pre0  = CH_PERCENT;
                d_pre_n = 2'd1;
              end
              default: begin
                // unknown conversion: percent then the letter
                d_pre0  = CH_PERCENT;
                d_pre1  = in_char;
                d_pre_n = 2'd2;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  // write limit and room checks
  logic [15:0]           size_m1;
  logic [LW-1:0]         lim_wide;
  logic [COUNT_BITS-1:0] lim;
  logic                  room;
  logic [NW:0]           num_len;
  logic [LW-1:0]         count_wide;
  logic [15:0]           pos;
  logic                  out_emit;

  assign size_m1    = (buffer_size == 16'd0) ? 16'd0 : buffer_size - 16'd1;
  assign lim_wide   = LW'(size_m1);
  assign lim        = (lim_wide > CMASK) ? CMASK[COUNT_BITS-1:0] : lim_wide[COUNT_BITS-1:0];
  assign room       = count < lim;
  assign num_len    = {1'b0, nd} + {{NW{1'b0}}, neg};
  assign count_wide = LW'(count);
  assign pos        = count_wide[15:0];

  // a new beat is loaded into the output register this cycle
  assign out_emit = (cmd.pre_emit && room) || cmd.num_emit || cmd.term_emit;

  // one digit per step: reciprocal multiply for base ten, shift for hex
  logic [63:0] prod;
  logic [31:0] q10;
  logic [3:0]  rem10;
  logic [31:0] q_next;
  logic [3:0]  rem;
  logic [NW-1:0] nd_m1;
  logic [3:0]  digit;

  assign prod   = 64'(mag) * 64'(RECIP10);
  assign q10    = 32'(prod >> RECIP_SHIFT);
  assign rem10  = mag[3:0] - ({q10[0], 3'b000} + {q10[2:0], 1'b0});
  assign q_next = base16 ? {4'd0, mag[31:4]} : q10;
  assign rem    = base16 ? mag[3:0] : rem10;
  assign nd_m1  = nd - NW'(1);
  assign digit  = scratch[nd_m1[IW-1:0]];

  assign stat.num_en   = num_en;
  assign stat.end_en   = end_en;
  assign stat.pre_left = pre_n != 2'd0;
  assign stat.div_done = (nd != '0) && ((mag == 32'd0) || (nd == NW'(DIGIT_SLOTS)));
  assign stat.num_fits = room && (COUNT_BITS'(num_len) <= (lim - count));
  assign stat.num_last = !neg && (nd == NW'(1));
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      after_percent <= 1'b0;
      in_string_arg <= 1'b0;
      pre_n         <= 2'd0;
      num_en        <= 1'b0;
      base16        <= 1'b0;
      neg           <= 1'b0;
      end_en        <= 1'b0;
      nd            <= '0;
      out_valid     <= 1'b0;
    end else begin
      // hold until taken, reload when a new beat is produced
      out_valid <= out_emit || (out_valid && !out_ready);
      if (cmd.load) begin
        pre_n         <= d_pre_n;
        num_en        <= d_num_en;
        base16        <= d_base16;
        neg           <= d_neg;
        end_en        <= d_end_en;
        after_percent <= d_apf;
        in_string_arg <= d_str;
        nd            <= '0;
      end
      if (cmd.div_step) begin
        nd <= nd + NW'(1);
      end
      if (cmd.pre_emit) begin
        pre_n <= pre_n - 2'd1;
        if (room) begin
          count <= count + COUNT_BITS'(1);
        end
      end
      if (cmd.num_emit) begin
        count <= count + COUNT_BITS'(1);
        if (neg) begin
          neg <= 1'b0;
        end else begin
          nd <= nd_m1;
        end
      end
      if (cmd.term_emit) begin
        count <= '0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pre0 <= d_pre0;
      pre1 <= d_pre1;
      mag  <= d_mag;
    end
    if (cmd.div_step) begin
      scratch[nd[IW-1:0]] <= rem;
      mag                 <= q_next;
    end
    if (cmd.pre_emit) begin
      pre0 <= pre1;
      if (room) begin
        out_char     <= pre0;
        out_position <= pos;
        is_end       <= 1'b0;
        total_length <= 16'd0;
      end
    end
    if (cmd.num_emit) begin
      out_char     <= neg ? CH_MINUS : digit_char(digit);
      out_position <= pos;
      is_end       <= 1'b0;
      total_length <= 16'd0;
    end
    if (cmd.term_emit) begin
      out_char     <= CH_NUL;
      out_position <= pos;
      is_end       <= 1'b1;
      total_length <= pos;
    end
  end

endmodule

[design/pfe_ctrl.sv]
// ----------------------------------------------------------------------------
// pfe_ctrl
// sequencer: decode, digit generation, prefix, fit check, number, terminator
// ----------------------------------------------------------------------------
module pfe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfe_pkg::pfe_stat_t stat,
  output pfe_pkg::pfe_cmd_t  cmd
);
  import pfe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PRE,
    S_CHK,
    S_NUM,
    S_TRM
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.num_en && !stat.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        if (!stat.pre_left) begin
          state_next = S_CHK;
        end else if (stat.out_free) begin
          cmd.pre_emit = 1'b1;
        end
      end
      S_CHK: begin
        // a number that does not fit is dropped whole
        state_next = (stat.num_en && stat.num_fits) ? S_NUM : S_TRM;
      end
      S_NUM: begin
        if (stat.out_free) begin
          cmd.num_emit = 1'b1;
          if (stat.num_last) begin
            state_next = S_TRM;
          end
        end
      end
      S_TRM: begin
        if (!stat.end_en) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.term_emit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

[design/printf_format_engine_unit.sv]
// ----------------------------------------------------------------------------
// printf_format_engine_unit
// minimal printf formatter: format and string beats in, buffer characters out
// ----------------------------------------------------------------------------
// flow: an accepted beat passes the decode and digit states, then a plain character
//   is loaded into the output register in the prefix state; one item at a time, with
//   the digit generator producing one digit per cycle and the output register taking
//   one character per cycle while the receiver is ready
// reset: rst is synchronous, active high; clears count, pending flags and the
//   sequencer, buffer_size returns to 256; the digit store is not cleared
module printf_format_engine_unit #(
  parameter int DIGIT_SLOTS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // in_char[7:0], arg_value[39:8]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // character stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_char[7:0], out_position[23:8],
                                      // total_length[39:24]
  output logic        m_axis_tlast    // is_end: terminator beat
);
  import pfe_pkg::*;

  localparam logic [15:0] BUFFER_SIZE_RESET = 16'd256;

  // buffer_size register at byte address 0
  logic [15:0] buffer_size;

  assign pready = 1'b1;
  assign prdata = {16'd0, buffer_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUFFER_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      buffer_size <= pwdata[15:0];
    end
  end

  pfe_cmd_t  cmd;
  pfe_stat_t stat;

  logic [7:0]  out_char;
  logic [15:0] out_position;
  logic [15:0] total_length;

  // sequencer: walks each item through decode, digits, prefix, number, end
  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: decode, digit generator, count and output register
  pfe_dp #(
    .DIGIT_SLOTS (DIGIT_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .buffer_size  (buffer_size),
    .req_type     (s_axis_tuser),
    .in_char      (s_axis_tdata[7:0]),
    .arg_value    (s_axis_tdata[39:8]),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_char     (out_char),
    .out_position (out_position),
    .is_end       (m_axis_tlast),
    .total_length (total_length)
  );

  assign m_axis_tdata = {total_length, out_position, out_char};

  // the sequencer is not ready in the cycle after taking an item
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while previous item still in work");

  // terminator beat reports its own position as the length
  a_term_length : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tdata[39:24] == m_axis_tdata[23:8] && m_axis_tdata[7:0] == CH_NUL))
    else $error("terminator beat length mismatch");

  // character beats carry a zero length field
  a_char_length : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[39:24] == 16'd0))
    else $error("nonzero length on character beat");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for printf_format_engine_unit: format, string and end
// beats go in, every character beat coming out is compared with a predicted
// copy of the engine across several buffer sizes, with random stalls
// ----------------------------------------------------------------------------
module tb;
  import pfe_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          TAIL_CYCLES  = 40;     // longest number plus output drain
  localparam int          RANDOM_ITEMS = 280;
  localparam int          NUM_PHASES   = 8;
  localparam logic [2:0]  ADDR_BUFFER_SIZE = 3'd0;
  localparam logic [1:0]  REQ_NONE     = 2'd3;   // unused request kind
  localparam logic [7:0]  LOWER_A      = "a";

  // one character beat leaving the engine
  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] pos;
    logic        is_end;
    logic [15:0] len;
  } char_beat_t;

  // one request beat, optionally with its characters typed in by hand
  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  ch;
    logic [31:0] arg;
    logic        typed;
    logic [3:0]  txt_len;
    logic [95:0] txt;
    logic [15:0] txt_pos;
  } request_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // in_char[7:0], arg_value[39:8]
  logic [1:0]  s_axis_tuser;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_char[7:0], out_position[23:8],
                               // total_length[39:24]
  logic        m_axis_tlast;   // is_end

  // predicted engine state
  logic [15:0] fmt_size;
  int unsigned fmt_count;
  bit          fmt_pending_pct;
  bit          fmt_in_string;

  char_beat_t  chars_due[$];     // characters still to come out, oldest first
  char_beat_t  fresh_chars[$];   // characters caused by the latest request
  char_beat_t  want_beat;
  request_t    directed[$];

  int mismatches;
  int items_sent;
  int chars_checked;
  int terminators_seen;
  int cycle_count;
  bit gaps_on;
  bit stall_on;

  logic [7:0] conv_letters [7];

  printf_format_engine_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run stops here if the engine hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d characters still due", cycle_count,
             chars_due.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // characters allowed before the terminator; a zero size acts like one
  function automatic int unsigned char_room();
    return (fmt_size == 16'd0) ? 0 : int'(fmt_size) - 1;
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    if (fmt_count >= char_room()) return;
    fresh_chars.push_back(char_beat_t'{c, fmt_count[15:0], 1'b0, 16'd0});
    fmt_count++;
  endfunction

  // a number goes out whole or not at all
  function automatic void emit_number(input logic [31:0] mag, input int unsigned base,
                                      input bit neg);
    logic [3:0]  digs [16];
    int unsigned nd;
    int unsigned room;
    room = char_room();
    if (fmt_count >= room) return;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % base);
      mag      = mag / base;
      nd++;
    end while (mag != 0 && nd < 16);
    if (nd + (neg ? 1 : 0) > room - fmt_count) return;
    if (neg) emit_char(CH_MINUS);
    while (nd > 0) begin
      nd--;
      emit_char((digs[nd] < 4'd10) ? CH_ZERO + 8'(digs[nd])
                                   : LOWER_A + 8'(digs[nd]) - 8'd10);
    end
  endfunction

  // works out the characters one request causes, into fresh_chars
  function automatic void format_request(input logic [1:0] req, input logic [7:0] c,
                                         input logic [31:0] arg);
    fresh_chars.delete();
    case (req)
      REQ_STR: begin
        if (fmt_in_string) begin
          if (c == CH_NUL) fmt_in_string = 1'b0;
          else emit_char(c);
        end
      end
      REQ_END: begin
        if (fmt_pending_pct) emit_char(CH_PERCENT);
        fresh_chars.push_back(char_beat_t'{CH_NUL, fmt_count[15:0], 1'b1,
                                           fmt_count[15:0]});
        fmt_count       = 0;
        fmt_pending_pct = 1'b0;
        fmt_in_string   = 1'b0;
      end
      REQ_FMT: begin
        fmt_in_string = 1'b0;
        if (c == CH_NUL) return;
        if (!fmt_pending_pct) begin
          if (c == CH_PERCENT) fmt_pending_pct = 1'b1;
          else emit_char(c);
          return;
        end
        fmt_pending_pct = 1'b0;
        case (c)
          CH_C: emit_char(arg[7:0]);
          CH_D, CH_I: begin
            if (arg[31]) emit_number(32'd0 - arg, 10, 1'b1);
            else emit_number(arg, 10, 1'b0);
          end
          CH_U: emit_number(arg, 10, 1'b0);
          CH_X: begin
            emit_char(CH_ZERO);
            emit_char(CH_X);
            emit_number(arg, 16, 1'b0);
          end
          CH_S: fmt_in_string = 1'b1;
          CH_PERCENT: emit_char(CH_PERCENT);
          default: begin
            // unknown conversion echoes itself
            emit_char(CH_PERCENT);
            emit_char(c);
          end
        endcase
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report(input string what, input logic [39:0] want, input logic [39:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h got %h", what, want, got);
  endtask

  // every character beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (chars_due.size() == 0) begin
        report("unexpected character beat", 40'd0, m_axis_tdata);
      end else begin
        want_beat = chars_due.pop_front();
        chars_checked++;
        if (m_axis_tlast) terminators_seen++;
        if (m_axis_tdata[7:0] != want_beat.ch)
          report("out_char", 40'(want_beat.ch), 40'(m_axis_tdata[7:0]));
        if (m_axis_tdata[23:8] != want_beat.pos)
          report("out_position", 40'(want_beat.pos), 40'(m_axis_tdata[23:8]));
        if (m_axis_tlast != want_beat.is_end)
          report("is_end", 40'(want_beat.is_end), 40'(m_axis_tlast));
        if (m_axis_tdata[39:24] != want_beat.len)
          report("total_length", 40'(want_beat.len), 40'(m_axis_tdata[39:24]));
      end
    end
  end

  // receiver stalls in bursts of random length
  initial begin
    int stall_left;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic request_t plain(input logic [1:0] req, input logic [7:0] c,
                                     input logic [31:0] arg);
    return request_t'{req, c, arg, 1'b0, 4'd0, 96'd0, 16'd0};
  endfunction

  // a row whose characters are written out by hand, starting at position p
  function automatic request_t known(input logic [1:0] req, input logic [7:0] c,
                                     input logic [31:0] arg, input int n,
                                     input logic [95:0] txt, input int p);
    return request_t'{req, c, arg, 1'b1, 4'(n), txt, 16'(p)};
  endfunction

  // one request beat, with an optional random gap ahead of it
  task automatic send_request(input request_t r);
    int gap;
    gap = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.arg, r.ch};
    s_axis_tuser  <= r.req;
    do @(posedge clk); while (!s_axis_tready);
    // accepted at this edge
    format_request(r.req, r.ch, r.arg);
    if (r.typed) begin
      for (int k = 0; k < int'(r.txt_len); k++)
        chars_due.push_back(char_beat_t'{r.txt[8*(int'(r.txt_len) - 1 - k) +: 8],
                                         r.txt_pos + 16'(k), 1'b0, 16'd0});
    end else begin
      foreach (fresh_chars[k]) chars_due.push_back(fresh_chars[k]);
    end
    items_sent++;
  endtask

  // sender holds off until every predicted character is out, then lets the
  // engine finish any silent work
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (chars_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // setup cycle then access cycle
  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_buffer_size();
    logic [31:0] got;
    apb_access(1'b0, ADDR_BUFFER_SIZE, 32'd0, got);
    if (got != 32'(fmt_size)) report("buffer_size read", 40'(fmt_size), 40'(got));
  endtask

  task automatic set_buffer_size(input logic [15:0] size);
    logic [31:0] unused;
    apb_access(1'b1, ADDR_BUFFER_SIZE, 32'(size), unused);
    fmt_size = size;
    check_buffer_size();
  endtask

  // arguments lean toward extremes and mixed magnitudes
  function automatic logic [31:0] pick_arg();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(0, 99));
      5: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // one random piece of a format string; counted collects items that matter
  task automatic random_piece(inout int counted);
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // literal character
      c = 8'($urandom_range(1, 255));
      if (c == CH_PERCENT) c = "L";
      send_request(plain(REQ_FMT, c, $urandom));
      counted += 1;
    end else if (pick < 75) begin
      // known conversion, string arguments with random content
      c = conv_letters[$urandom_range(0, 6)];
      send_request(plain(REQ_FMT, CH_PERCENT, $urandom));
      send_request(plain(REQ_FMT, c, pick_arg()));
      counted += 2;
      if (c == CH_S) begin
        n = $urandom_range(0, 6);
        repeat (n) send_request(plain(REQ_STR, 8'($urandom_range(1, 255)), $urandom));
        counted += n;
        if ($urandom_range(0, 3) != 0) begin
          send_request(plain(REQ_STR, CH_NUL, $urandom));
          counted += 1;
        end
      end
    end else if (pick < 80) begin
      // unknown conversion letter
      c = 8'($urandom_range(1, 255));
      if (c == CH_C || c == CH_D || c == CH_I || c == CH_U || c == CH_X ||
          c == CH_S || c == CH_PERCENT) c = "q";
      send_request(plain(REQ_FMT, CH_PERCENT, $urandom));
      send_request(plain(REQ_FMT, c, $urandom));
      counted += 2;
    end else if (pick < 88) begin
      // end of format, sometimes with a dangling percent
      if ($urandom_range(0, 1) == 0) begin
        send_request(plain(REQ_FMT, CH_PERCENT, $urandom));
        counted += 1;
      end
      send_request(plain(REQ_END, 8'($urandom), $urandom));
      counted += 1;
    end else begin
      // noise the engine should shrug off
      case ($urandom_range(0, 2))
        0: send_request(plain(REQ_FMT, CH_NUL, $urandom));
        1: send_request(plain(REQ_NONE, 8'($urandom), $urandom));
        default: send_request(plain(REQ_STR, 8'($urandom_range(1, 255)), $urandom));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] phase_sizes [NUM_PHASES];
    int          phase_items;

    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 40'd0;
    s_axis_tuser  = REQ_FMT;
    mismatches       = 0;
    items_sent       = 0;
    chars_checked    = 0;
    terminators_seen = 0;
    gaps_on  = 1'b1;
    stall_on = 1'b1;

    fmt_size        = 16'd256;
    fmt_count       = 0;
    fmt_pending_pct = 1'b0;
    fmt_in_string   = 1'b0;

    conv_letters = '{CH_C, CH_D, CH_I, CH_U, CH_X, CH_S, CH_PERCENT};
    // extremes of the size register, a lowered size after a roomy one, and back
    phase_sizes  = '{16'd1, 16'd0, 16'd12, 16'd3, 16'd65535, 16'd7, 16'd40, 16'd256};

    // directed rows: plain character, ignored beats, numeric extremes, every
    // conversion, a format character cutting a string argument short, a stray
    // string character, an unknown letter and a trailing percent
    directed.push_back(known(REQ_FMT, "A", 32'd0, 1, "A", 0));
    directed.push_back(known(REQ_FMT, CH_NUL, 32'hffff_ffff, 0, 96'd0, 0));
    directed.push_back(known(REQ_NONE, "r", 32'h5a5a_5a5a, 0, 96'd0, 0));
    directed.push_back(known(REQ_FMT, CH_PERCENT, 32'd0, 0, 96'd0, 0));
    directed.push_back(known(REQ_FMT, CH_I, 32'h8000_0000, 11, "-2147483648", 1));
    directed.push_back(plain(REQ_FMT, CH_PERCENT, 32'd0));
    directed.push_back(known(REQ_FMT, CH_U, 32'hffff_ffff, 10, "4294967295", 12));
    directed.push_back(plain(REQ_FMT, CH_PERCENT, 32'd0));
    directed.push_back(known(REQ_FMT, CH_X, 32'hffff_ffff, 10, "0xffffffff", 22));
    directed.push_back(plain(REQ_FMT, CH_PERCENT, 32'd0));
    directed.push_back(plain(REQ_FMT, CH_D, 32'h7fff_ffff));
    directed.push_back(plain(REQ_FMT, CH_PERCENT, 32'd0));
    directed.push_back(plain(REQ_FMT, CH_C, 32'hffff_ff41));
    directed.push_back(plain(REQ_FMT, CH_PERCENT, 32'd0));
    directed.push_back(plain(REQ_FMT, CH_PERCENT, 32'd0));
    directed.push_back(plain(REQ_FMT, CH_PERCENT, 32'd0));
    directed.push_back(plain(REQ_FMT, CH_S, 32'd0));
    directed.push_back(plain(REQ_STR, "h", 32'd0));
    directed.push_back(plain(REQ_STR, 8'hff, 32'd0));
    directed.push_back(plain(REQ_FMT, "B", 32'd0));
    directed.push_back(plain(REQ_STR, "z", 32'd0));
    directed.push_back(plain(REQ_FMT, CH_PERCENT, 32'd0));
    directed.push_back(plain(REQ_FMT, "q", 32'd0));
    directed.push_back(plain(REQ_FMT, CH_PERCENT, 32'd0));
    directed.push_back(plain(REQ_END, CH_NUL, 32'd0));

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // size register comes out of reset at 256
    check_buffer_size();

    foreach (directed[k]) send_request(directed[k]);
    settle();

    // random phases, one buffer size each; count carries over between phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) begin
        // closing stretch runs without gaps or stalls
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end else begin
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      set_buffer_size(phase_sizes[ph]);
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / NUM_PHASES) random_piece(phase_items);
      settle();
    end

    if (chars_due.size() != 0) begin
      mismatches++;
      $display("%0d predicted characters never came out", chars_due.size());
    end

    $display("sent %0d request beats over %0d buffer sizes plus a directed set",
             items_sent, NUM_PHASES);
    $display("compared %0d character beats, %0d of them terminators, %0d mismatches",
             chars_checked, terminators_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/pfe_pkg.sv
design/pfe_dp.sv
design/pfe_ctrl.sv
design/printf_format_engine_unit.sv
dv/tb.sv
